// ===== src/fgtd_pkg.sv =====
package fgtd_pkg;

    localparam int DATA_WIDTH_DEF = 31;

    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic go;
        logic op;
    } arith_cmd_t;

endpackage

// ===== src/fgtd_arith.sv =====
module fgtd_arith #(
    parameter int DATA_WIDTH = fgtd_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fgtd_pkg::arith_cmd_t   cmd,
    input  logic [DATA_WIDTH-1:0]  opa,
    input  logic [DATA_WIDTH-1:0]  opb,
    output logic [DATA_WIDTH-1:0]  quo,
    output logic [DATA_WIDTH-1:0]  acc,
    output logic                   done
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic                  op_reg, op_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH:0]   y_reg, y_next;
    logic [DATA_WIDTH-1:0] z_reg, z_next;

    logic [DATA_WIDTH:0]   shifted;
    logic                  ge;

    // one bit per cycle: restoring divide or shift-add multiply
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        shifted   = {y_reg[DATA_WIDTH-1:0], x_reg[DATA_WIDTH-1]};
        ge        = shifted >= {1'b0, z_reg};
        if (cmd.go)
        begin
            run_next = 1'b1;
            op_next  = cmd.op;
            cnt_next = '0;
            x_next   = opa;
            y_next   = '0;
            z_next   = opb;
        end
        else if (run_reg)
        begin
            if (op_reg == fgtd_pkg::OP_DIV)
            begin
                y_next = ge ? (shifted - {1'b0, z_reg}) : shifted;
                x_next = {x_reg[DATA_WIDTH-2:0], ge};
            end
            else
            begin
                y_next = {1'b0, y_reg[DATA_WIDTH-1:0] + (z_reg[0] ? x_reg : '0)};
                x_next = {x_reg[DATA_WIDTH-2:0], 1'b0};
                z_next = {1'b0, z_reg[DATA_WIDTH-1:1]};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DATA_WIDTH - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= fgtd_pkg::OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign quo  = x_reg;
    assign acc  = y_reg[DATA_WIDTH-1:0];
    assign done = done_reg;

endmodule

// ===== src/factorial_gcd_trial_division.sv =====
// gcd of fact_arg factorial and other_arg, by trial division of other_arg
// and the exponent sum of each prime in the factorial.
// input: a word is taken at a rising edge where start is high and busy is
// low; fact_arg and other_arg are sampled at that edge. busy stays high
// until the result has been produced.
// output: done is high for exactly one cycle when gcd_value is valid. the
// receiver cannot stall done; the result stays readable after that cycle.
// gcd_value holds the last result until the next word is accepted.
// timing: all arithmetic runs through one bit-serial divide/multiply unit.
// every trial candidate p with p*p <= remaining cofactor costs one divide
// plus a pass through the compare state; each prime factor found adds a
// divide per multiplicity, one per exponent term and one multiply per
// taken power. in the worst case the number of trial candidates grows
// with sqrt(other_arg).
// a new word can be accepted in the cycle done is high.
// reset: asynchronous, returns to idle and drops done; gcd_value is not cleared.
module factorial_gcd_trial_division #(
    parameter int DATA_WIDTH = fgtd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] fact_arg,
    input  logic [DATA_WIDTH-1:0] other_arg,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] gcd_value
);

    localparam int DW = $clog2(DATA_WIDTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_TDIV  = 4'd2;
    localparam logic [3:0] S_SDIV  = 4'd3;
    localparam logic [3:0] S_LEG   = 4'd4;
    localparam logic [3:0] S_LDIV  = 4'd5;
    localparam logic [3:0] S_PMUL  = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_FMUL  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] rest_reg, rest_next;
    logic [DATA_WIDTH-1:0] p_reg, p_next;
    logic [DATA_WIDTH:0]   sq_reg, sq_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;
    logic [DATA_WIDTH-1:0] t_reg, t_next;
    logic [DATA_WIDTH-1:0] sum_reg, sum_next;
    logic [DW-1:0]         d1_reg, d1_next;
    logic [DW-1:0]         times_reg, times_next;

    fgtd_pkg::arith_cmd_t  a_cmd;
    logic [DATA_WIDTH-1:0] op_x, op_z;
    logic [DATA_WIDTH-1:0] a_quo, a_acc;
    logic                  a_done;

    fgtd_arith #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_arith (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (a_cmd),
        .opa  (op_x),
        .opb  (op_z),
        .quo  (a_quo),
        .acc  (a_acc),
        .done (a_done)
    );

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        a_next      = a_reg;
        rest_next   = rest_reg;
        p_next      = p_reg;
        sq_next     = sq_reg;
        result_next = result_reg;
        t_next      = t_reg;
        sum_next    = sum_reg;
        d1_next     = d1_reg;
        times_next  = times_reg;
        a_cmd.go    = 1'b0;
        a_cmd.op    = fgtd_pkg::OP_DIV;
        op_x        = rest_reg;
        op_z        = p_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next      = fact_arg;
                    rest_next   = other_arg;
                    p_next      = DATA_WIDTH'(2);
                    sq_next     = (DATA_WIDTH + 1)'(4);
                    result_next = DATA_WIDTH'(1);
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sq_reg <= {1'b0, rest_reg})
                begin
                    a_cmd.go   = 1'b1;
                    state_next = S_TDIV;
                end
                else if (a_reg >= rest_reg)
                begin
                    a_cmd.go   = 1'b1;
                    a_cmd.op   = fgtd_pkg::OP_MUL;
                    op_x       = result_reg;
                    op_z       = rest_reg;
                    state_next = S_FMUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TDIV:
            begin
                if (a_done)
                begin
                    if (a_acc == '0)
                    begin
                        rest_next  = a_quo;
                        d1_next    = DW'(1);
                        a_cmd.go   = 1'b1;
                        op_x       = a_quo;
                        state_next = S_SDIV;
                    end
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        sq_next    = sq_reg + {p_reg, 1'b1};
                        state_next = S_CHECK;
                    end
                end
            end
            S_SDIV:
            begin
                if (a_done)
                begin
                    if (a_acc == '0)
                    begin
                        rest_next = a_quo;
                        d1_next   = d1_reg + 1'b1;
                        a_cmd.go  = 1'b1;
                        op_x      = a_quo;
                    end
                    else
                    begin
                        t_next     = a_reg;
                        sum_next   = '0;
                        state_next = S_LEG;
                    end
                end
            end
            S_LEG:
            begin
                // exponent sum only matters up to the multiplicity
                if (t_reg == '0 || sum_reg >= DATA_WIDTH'(d1_reg))
                begin
                    times_next = (sum_reg < DATA_WIDTH'(d1_reg)) ? sum_reg[DW-1:0] : d1_reg;
                    state_next = S_PMUL;
                end
                else
                begin
                    a_cmd.go   = 1'b1;
                    op_x       = t_reg;
                    state_next = S_LDIV;
                end
            end
            S_LDIV:
            begin
                if (a_done)
                begin
                    t_next     = a_quo;
                    sum_next   = sum_reg + a_quo;
                    state_next = S_LEG;
                end
            end
            S_PMUL:
            begin
                if (times_reg == '0)
                begin
                    p_next     = p_reg + 1'b1;
                    sq_next    = sq_reg + {p_reg, 1'b1};
                    state_next = S_CHECK;
                end
                else
                begin
                    a_cmd.go   = 1'b1;
                    a_cmd.op   = fgtd_pkg::OP_MUL;
                    op_x       = result_reg;
                    times_next = times_reg - 1'b1;
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT:
            begin
                if (a_done)
                begin
                    result_next = a_acc;
                    state_next  = S_PMUL;
                end
            end
            S_FMUL:
            begin
                if (a_done)
                begin
                    result_next = a_acc;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        rest_reg   <= rest_next;
        p_reg      <= p_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
        t_reg      <= t_next;
        sum_reg    <= sum_next;
        d1_reg     <= d1_next;
        times_reg  <= times_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign gcd_value = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_unit_wait: assert property (@(posedge clk) disable iff (!rst_n)
        a_done |-> (state_reg == S_TDIV || state_reg == S_SDIV || state_reg == S_LDIV
                    || state_reg == S_MWAIT || state_reg == S_FMUL))
        else $error("arithmetic unit finished outside a wait state");

endmodule
